// ===== rtl/nearest_palette_colour_search_top_assert.svh =====
// Assertion macros for the nearest palette colour search checker.
`ifndef NEAREST_PALETTE_COLOUR_SEARCH_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOUR_SEARCH_TOP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PNC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed in %m");

// Consequent must hold in the same cycle as the antecedent.
`define PNC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed in %m");

`endif

// ===== rtl/pnc_pkg.sv =====
// Types and constants of the nearest palette colour search.
package pnc_pkg;

   localparam int COMP_W   = 8;
   localparam int IDX_W    = 8;
   localparam int DIST_W   = 18;
   localparam int COLOUR_W = 15;
   localparam int SQ_W     = 2 * COMP_W;

   // largest reachable distance: three components, each off by at most 252
   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(3 * 252 * 252);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] index;
   } scan_ctl_type;

endpackage

// ===== rtl/nearest_palette_colour_search_top.sv =====
// Top level of the nearest palette colour search.
//
// Usage:
//   Input words are taken on the command channel at a rising edge where start
//   is high and busy is low. A load word (req_operation low) writes red, green
//   and blue into palette entry req_entry_index; busy stays low
//   and no result follows. Loads at or past PALETTE_ENTRIES are dropped.
//   A match word (req_operation high) expands req_colour_word to 8-bit
//   components (5-bit field times 8 plus 4) and scans every entry.
//
//   The palette lives in a ring of PALETTE_ENTRIES cells. During a match the
//   ring rotates one place per cycle, so the head cell shows entry k in scan
//   cycle k; after a full turn every entry is back in its own cell. A distance
//   pipe of two register stages (difference, square) and a final sum follows
//   the head, and the running minimum keeps the lowest index on ties.
//
//   A match holds busy through the ring turn and the pipe drain. rsp_valid
//   pulses for one cycle on the edge busy drops, with rsp_best_index and
//   rsp_best_distance; a new word may be taken in that same cycle. The
//   receiver cannot stall the result.
//   Reset clears the sequencer, pipe valids and strobe only; the palette holds
//   whatever it had and every entry must be loaded before the first match.
module nearest_palette_colour_search_top #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [pnc_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [pnc_pkg::COMP_W-1:0]        req_red,
   input  logic [pnc_pkg::COMP_W-1:0]        req_green,
   input  logic [pnc_pkg::COMP_W-1:0]        req_blue,
   input  logic [pnc_pkg::COLOUR_W-1:0]      req_colour_word,
   output logic                              rsp_valid,
   output logic [pnc_pkg::IDX_W-1:0]         rsp_best_index,
   output logic [pnc_pkg::DIST_W-1:0]        rsp_best_distance
);
   import pnc_pkg::*;

   localparam int CNT_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rgb_type            query_ff, query_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic               accept;
   logic               load_acc;
   logic               shift_en;
   rgb_type            load_data;
   rgb_type            cell_q [PALETTE_ENTRIES];
   scan_ctl_type       scan_ctl;
   scan_ctl_type       dist_ctl;
   logic [DIST_W-1:0]  entry_dist;
   logic               take;

   assign accept   = start && !busy;
   assign load_acc = accept && (req_operation == OP_LOAD);
   assign shift_en = (state_ff == ST_SCAN);

   assign load_data.red   = req_red;
   assign load_data.green = req_green;
   assign load_data.blue  = req_blue;

   // palette ring: each cell takes its upper neighbor, the top wraps to cell 0
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      pnc_cell u_cell (
         .clock     (clock),
         .load_en   (load_acc && (req_entry_index == IDX_W'(i))),
         .load_data (load_data),
         .shift_en  (shift_en),
         .shift_in  (cell_q[(i + 1) % PALETTE_ENTRIES]),
         .entry     (cell_q[i])
      );
   end

   assign scan_ctl.valid = shift_en;
   assign scan_ctl.last  = (count_ff == CNT_LAST);
   assign scan_ctl.index = IDX_W'(count_ff);

   pnc_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .query   (query_ff),
      .entry   (cell_q[0]),
      .ctl_in  (scan_ctl),
      .dist_sq (entry_dist),
      .ctl_out (dist_ctl)
   );

   // entry 0 always seeds the minimum; later entries win only when strictly closer
   assign take = (dist_ctl.index == '0) || (entry_dist < best_dist_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      query_in     = query_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_dist_in  = rsp_dist_ff;
      rsp_idx_in   = rsp_idx_ff;

      if (dist_ctl.valid && take) begin
         best_dist_in = entry_dist;
         best_idx_in  = dist_ctl.index;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_MATCH)) begin
               query_in.red   = {req_colour_word[4:0],   3'b100};
               query_in.green = {req_colour_word[9:5],   3'b100};
               query_in.blue  = {req_colour_word[14:10], 3'b100};
               count_in       = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            count_in = count_ff + 1'b1;
            if (scan_ctl.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last entry leaves the distance pipe
            if (dist_ctl.valid && dist_ctl.last) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = best_dist_in;
               rsp_idx_in   = best_idx_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff     <= query_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

// ===== rtl/pnc_cell.sv =====
// One palette cell: holds an entry, takes a load or its neighbor's entry.
module pnc_cell (
   input  logic             clock,
   input  logic             load_en,
   input  pnc_pkg::rgb_type load_data,
   input  logic             shift_en,
   input  pnc_pkg::rgb_type shift_in,
   output pnc_pkg::rgb_type entry
);
   import pnc_pkg::*;

   rgb_type entry_ff;
   rgb_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/pnc_dist.sv =====
// Pipelined squared RGB distance: difference, square, then sum.
module pnc_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  pnc_pkg::rgb_type              query,
   input  pnc_pkg::rgb_type              entry,
   input  pnc_pkg::scan_ctl_type         ctl_in,
   output logic [pnc_pkg::DIST_W-1:0]    dist_sq,
   output pnc_pkg::scan_ctl_type         ctl_out
);
   import pnc_pkg::*;

   function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   rgb_type                  diff_ff, diff_in;
   scan_ctl_type             ctl_a_ff, ctl_b_ff;
   logic [SQ_W-1:0]          sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]          sq_r_in, sq_g_in, sq_b_in;

   always_comb begin
      diff_in.red   = abs_diff(query.red,   entry.red);
      diff_in.green = abs_diff(query.green, entry.green);
      diff_in.blue  = abs_diff(query.blue,  entry.blue);
      sq_r_in = SQ_W'(diff_ff.red)   * SQ_W'(diff_ff.red);
      sq_g_in = SQ_W'(diff_ff.green) * SQ_W'(diff_ff.green);
      sq_b_in = SQ_W'(diff_ff.blue)  * SQ_W'(diff_ff.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
      end else begin
         ctl_a_ff.valid <= ctl_in.valid;
         ctl_b_ff.valid <= ctl_a_ff.valid;
      end
      ctl_a_ff.last  <= ctl_in.last;
      ctl_a_ff.index <= ctl_in.index;
      ctl_b_ff.last  <= ctl_a_ff.last;
      ctl_b_ff.index <= ctl_a_ff.index;
      diff_ff <= diff_in;
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
   end

   assign dist_sq = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   assign ctl_out = ctl_b_ff;

endmodule

// ===== rtl/pnc_checker.sv =====
// Port-level checker for the nearest palette colour search, bound to the top.
`include "nearest_palette_colour_search_top_assert.svh"

module pnc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_operation,
   input logic                        rsp_valid,
   input logic [pnc_pkg::DIST_W-1:0]  rsp_best_distance
);
   import pnc_pkg::*;

   `PNC_ASSERT_NEXT(a_match_goes_busy, start && !busy && (req_operation == OP_MATCH), busy)
   `PNC_ASSERT_NEXT(a_load_stays_idle, start && !busy && (req_operation == OP_LOAD), !busy)
   `PNC_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   `PNC_ASSERT_SAME(a_result_ends_match, rsp_valid, !busy && $past(busy))
   `PNC_ASSERT_SAME(a_distance_bound, rsp_valid, rsp_best_distance <= DIST_MAX)

endmodule

bind nearest_palette_colour_search_top pnc_checker u_pnc_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the nearest palette colour search block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pnc_pkg::*;

   localparam int PALETTE_ENTRIES = 256;
   // Start the running minimum above any reachable distance.
   localparam int FAR_DISTANCE    = 10000 * 10000;
   localparam int RANDOM_WORDS    = 80;
   localparam int STEADY_WORDS    = 50;
   // Cycles one match may need: ring turn, pipe drain and some margin.
   localparam int MATCH_CYCLES    = PALETTE_ENTRIES + 8;

   typedef struct {
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] distance;
   } match_result_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                start             = 1'b0;
   logic                busy;
   logic                req_operation     = OP_LOAD;
   logic [IDX_W-1:0]    req_entry_index   = '0;
   logic [COMP_W-1:0]   req_red           = '0;
   logic [COMP_W-1:0]   req_green         = '0;
   logic [COMP_W-1:0]   req_blue          = '0;
   logic [COLOUR_W-1:0] req_colour_word   = '0;
   logic                rsp_valid;
   logic [IDX_W-1:0]    rsp_best_index;
   logic [DIST_W-1:0]   rsp_best_distance;

   // Our own copy of the palette, updated as each load word is accepted.
   rgb_type          palette_mirror [PALETTE_ENTRIES];
   // Nearest-entry answers still owed by the block, oldest first.
   match_result_type pending_matches [$];
   int               mismatch_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nearest_palette_colour_search_top #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_dut (
      .*
   );

   // Expand a 15-bit colour word to 8-bit components: field times 8, plus 4.
   function automatic rgb_type colour_to_rgb(input logic [COLOUR_W-1:0] colour);
      rgb_type expanded;
      expanded.red   = {colour[4:0],   3'b100};
      expanded.green = {colour[9:5],   3'b100};
      expanded.blue  = {colour[14:10], 3'b100};
      return expanded;
   endfunction

   // Pick the colour word whose expansion lies closest to an 8-bit entry.
   function automatic logic [COLOUR_W-1:0] quantize(input rgb_type entry);
      return {entry.blue[7:3], entry.green[7:3], entry.red[7:3]};
   endfunction

   // Scan the mirrored palette in ascending order; strict less-than keeps
   // the lowest index on ties.
   function automatic match_result_type nearest_entry(input logic [COLOUR_W-1:0] colour);
      rgb_type          target;
      int               best_distance;
      int               best_index;
      int               dr;
      int               dg;
      int               db;
      int               distance;
      match_result_type answer;
      target        = colour_to_rgb(colour);
      best_distance = FAR_DISTANCE;
      best_index    = 0;
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         dr       = int'(target.red)   - int'(palette_mirror[k].red);
         dg       = int'(target.green) - int'(palette_mirror[k].green);
         db       = int'(target.blue)  - int'(palette_mirror[k].blue);
         distance = dr * dr + dg * dg + db * db;
         if (distance < best_distance) begin
            best_distance = distance;
            best_index    = k;
         end
      end
      answer.index    = best_index[IDX_W-1:0];
      answer.distance = best_distance[DIST_W-1:0];
      return answer;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Present one word and hold it until the block takes it, then update the
   // mirror or queue the expected answer. Leave start high: the caller either
   // presents the next word at this edge or drops start in a gap.
   task automatic send_word(input logic                op,
                            input logic [IDX_W-1:0]    index,
                            input rgb_type             entry,
                            input logic [COLOUR_W-1:0] colour);
      req_operation   <= op;
      req_entry_index <= index;
      req_red         <= entry.red;
      req_green       <= entry.green;
      req_blue        <= entry.blue;
      req_colour_word <= colour;
      start           <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      if (op == OP_LOAD) begin
         if (int'(index) < PALETTE_ENTRIES) begin
            palette_mirror[index] = entry;
         end
      end else begin
         pending_matches.push_back(nearest_entry(colour));
      end
   endtask

   // Loads carry a random colour word and matches random index and
   // components, so the unused fields toggle too.
   task automatic load_entry(input logic [IDX_W-1:0] index, input rgb_type entry);
      send_word(OP_LOAD, index, entry, COLOUR_W'($urandom));
   endtask

   task automatic match_colour(input logic [COLOUR_W-1:0] colour);
      send_word(OP_MATCH, IDX_W'($urandom), rgb_type'(24'($urandom)), colour);
   endtask

   // Drop start for a random burst now and then, scrambling the fields.
   task automatic sender_gap();
      if ($urandom_range(0, 3) == 0) begin
         start           <= 1'b0;
         req_operation   <= 1'($urandom);
         req_entry_index <= IDX_W'($urandom);
         req_red         <= COMP_W'($urandom);
         req_green       <= COMP_W'($urandom);
         req_blue        <= COMP_W'($urandom);
         req_colour_word <= COLOUR_W'($urandom);
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // One random word: loads that often duplicate an entry or land exactly on
   // an expanded colour, and matches often aimed right at a stored entry.
   task automatic random_word();
      int                  choice;
      rgb_type             entry;
      logic [COLOUR_W-1:0] colour;
      choice = $urandom_range(0, 9);
      if (choice < 5) begin
         case (choice)
            0: begin
               entry = palette_mirror[$urandom_range(0, PALETTE_ENTRIES - 1)];
            end
            1: begin
               entry = colour_to_rgb(COLOUR_W'($urandom));
            end
            default: begin
               entry = rgb_type'(24'($urandom));
            end
         endcase
         load_entry(IDX_W'($urandom), entry);
      end else begin
         if (choice < 7) begin
            colour = quantize(palette_mirror[$urandom_range(0, PALETTE_ENTRIES - 1)]);
         end else begin
            colour = COLOUR_W'($urandom);
         end
         match_colour(colour);
      end
   endtask

   // Every entry must hold a value before the first match. Put black at 0 and
   // white at the top, and repeat an entry now and then to seed ties.
   task automatic test_fill_palette();
      rgb_type entry;
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         if (k == 0) begin
            entry = '0;
         end else if (k == PALETTE_ENTRIES - 1) begin
            entry = '1;
         end else if (k % 8 == 0) begin
            entry = palette_mirror[k - 1];
         end else begin
            entry = rgb_type'(24'($urandom));
         end
         send_word(OP_LOAD, IDX_W'(k), entry, COLOUR_W'($urandom));
      end
   endtask

   // Darkest and brightest words and each component alone at full scale.
   task automatic test_corner_colours();
      match_colour(15'h0000);
      match_colour(15'h7FFF);
      match_colour(15'h001F);
      match_colour(15'h03E0);
      match_colour(15'h7C00);
   endtask

   // Equal distances at several entries must resolve to the lowest index.
   task automatic test_ties();
      logic [COLOUR_W-1:0] colour;
      rgb_type             entry;
      colour = COLOUR_W'($urandom);
      send_word(OP_LOAD, 8'd9, colour_to_rgb(colour), COLOUR_W'($urandom));
      send_word(OP_LOAD, 8'd4, colour_to_rgb(colour), COLOUR_W'($urandom));
      match_colour(colour);
      // Different entries at the same nonzero distance from the target.
      colour      = COLOUR_W'($urandom);
      entry       = colour_to_rgb(colour);
      entry.red   = entry.red + 8'd1;
      send_word(OP_LOAD, 8'd201, entry, COLOUR_W'($urandom));
      entry       = colour_to_rgb(colour);
      entry.green = entry.green - 8'd1;
      send_word(OP_LOAD, 8'd200, entry, COLOUR_W'($urandom));
      match_colour(colour);
      // Exact hit on entry 0: the scan must consider it from the start.
      colour = COLOUR_W'($urandom);
      send_word(OP_LOAD, 8'd0, colour_to_rgb(colour), COLOUR_W'($urandom));
      match_colour(colour);
   endtask

   task automatic test_random_traffic();
      repeat (RANDOM_WORDS) begin
         sender_gap();
         random_word();
      end
   endtask

   // Close with no gaps: each word waits only on busy, so a new word lands
   // in the very cycle a result strobes out.
   task automatic test_back_to_back();
      repeat (STEADY_WORDS) begin
         random_word();
      end
   endtask

   // Check each strobed result against the oldest expected answer. Sample on
   // the rising edge, so the block's own updates at that edge are not seen.
   always @(posedge clock) begin
      match_result_type wanted;
      if (!reset && rsp_valid) begin
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected result index %0d distance %0d",
                                      rsp_best_index, rsp_best_distance));
         end else begin
            wanted = pending_matches.pop_front();
            if (rsp_best_index !== wanted.index) begin
               report_mismatch($sformatf("best_index %0d, want %0d",
                                         rsp_best_index, wanted.index));
            end
            if (rsp_best_distance !== wanted.distance) begin
               report_mismatch($sformatf("best_distance %0d, want %0d",
                                         rsp_best_distance, wanted.distance));
            end
         end
      end
   end

   initial begin
      // Hold reset, then release it.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_fill_palette();
      test_corner_colours();
      test_ties();
      test_random_traffic();
      test_back_to_back();

      // Drop start, drain the outstanding matches, then let the pipe settle
      // so a stray extra result would still be caught.
      start <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (MATCH_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Bound the run: the slowest correct run is well under a millisecond.
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
